[hw/rtl/tgag_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tgag_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIFT       = 2'd2;

  localparam logic [31:0] CYCLE_RATE_RST = 32'd4295;
  localparam logic [14:0] STRIDE_RST     = 15'd1608;
  localparam logic [14:0] LIFT_RST       = 15'd1229;

  localparam logic [3:0] DIR_STOP = 4'd8;
  localparam logic [2:0] LEG_LAST = 3'd5;

  // legs 1, 2 and 5 run with their phase offset by half a turn
  localparam logic [5:0] LAG_MASK = 6'b100110;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic signed [15:0] DIR_COEF [8][6] = '{
    '{-16'sd8192,   16'sd8192, -16'sd16384,  16'sd16384,  -16'sd8192,   16'sd8192},
    '{ 16'sd8192,  -16'sd8192,  16'sd16384, -16'sd16384,   16'sd8192,  -16'sd8192},
    '{ 16'sd14189,  16'sd14189,  16'sd0,      16'sd0,     -16'sd14189, -16'sd14189},
    '{-16'sd14189, -16'sd14189,  16'sd0,      16'sd0,      16'sd14189,  16'sd14189},
    '{ 16'sd4240,   16'sd15826, -16'sd11585,  16'sd11585, -16'sd15826,  -16'sd4240},
    '{-16'sd15826,  -16'sd4240, -16'sd11585,  16'sd11585,   16'sd4240,  16'sd15826},
    '{ 16'sd15826,   16'sd4240,  16'sd11585, -16'sd11585,  -16'sd4240, -16'sd15826},
    '{ -16'sd4240, -16'sd15826,  16'sd11585, -16'sd11585,  16'sd15826,   16'sd4240}
  };

  function automatic logic signed [15:0] sat18(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Q30 Taylor series of sin(x), seven terms, result unsigned Q0.16
  function automatic logic [15:0] sine_entry(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [15:0]        r;
    x2 = (x * x) >> 30;
    t  = x;
    s  = $signed(x);
    t  = ((t * x2) >> 30) / 64'd6;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + $signed(t);
    t  = ((t * x2) >> 30) / 64'd110;
    s  = s - $signed(t);
    t  = ((t * x2) >> 30) / 64'd156;
    s  = s + $signed(t);
    if (s < 0) begin
      s = 64'sd0;
    end
    s = (s + 64'sd8192) >>> 14;
    if (s > 64'sd65535) begin
      r = 16'hffff;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tgag_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none

module tgag_sine_rom #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic [AW-1:0] addr_i,
  output logic      [15:0]   data_o
);

  logic [15:0] rom_w [DEPTH];
  logic [15:0] data_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_rom
    localparam logic [63:0] K = (2 * i > DEPTH) ? 64'(DEPTH - i) : 64'(i);
    localparam logic [63:0] X = tgag_pkg::PI_Q30 * K / DEPTH;
    assign rom_w[i] = tgag_pkg::sine_entry(X);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[hw/rtl/tgag_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module tgag_mul (
  input  wire logic               clk_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed      [64:0] p_o
);

  logic signed [64:0] p_d;
  logic signed [64:0] p_q;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

[hw/rtl/tripod_gait_angle_generator_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Tripod gait angle generator. Each accepted tick yields six poses, legs 0 to 5 in
// order, the sixth flagged by last_leg_o. One registered multiplier is shared by all
// steps. A walking tick is accepted, then ST_PHASE and ST_ADV advance the phase and
// ST_LEG0 to ST_LEG3 per leg handle the projection, the swing product and the lift;
// a standing or stopped tick uses ST_LEG0 and ST_LEG3 per leg. The output side can
// hold a tick in ST_LEG3. The block is not ready while a tick is in progress. The
// half-sine table is a constant ROM of SINE_TABLE_DEPTH entries, registered read;
// no clearing pass. Configuration writes are expected only while the block is idle.
module tripod_gait_angle_generator_top #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tgag_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           walking_i,
  input  wire logic [3:0]                     direction_i,
  input  wire logic [15:0]                    delta_time_i,
  input  wire logic signed [15:0]             stand_middle_i,
  input  wire logic signed [15:0]             stand_distal_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [2:0]                          leg_index_o,
  output logic signed [15:0]                  root_angle_o,
  output logic signed [15:0]                  middle_angle_o,
  output logic signed [15:0]                  distal_angle_o,
  output logic                                last_leg_o
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam logic [IDX_W:0] DEPTH_C = (IDX_W + 1)'(SINE_TABLE_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PHASE = 3'd1;
  localparam logic [2:0] ST_ADV   = 3'd2;
  localparam logic [2:0] ST_LEG0  = 3'd3;
  localparam logic [2:0] ST_LEG1  = 3'd4;
  localparam logic [2:0] ST_LEG2  = 3'd5;
  localparam logic [2:0] ST_LEG3  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [2:0]         leg_q, leg_d;
  logic [31:0]        phase_q, phase_d;
  logic [31:0]        rate_q;
  logic [14:0]        stride_q;
  logic [14:0]        lift_q;

  logic               still_q;
  logic [3:0]         dir_q;
  logic [15:0]        dt_q;
  logic signed [15:0] smid_q;
  logic signed [15:0] sdist_q;

  logic signed [31:0] d_q;
  logic               first_q;
  logic signed [15:0] root_q;

  logic               out_valid_q;
  logic [2:0]         out_leg_q;
  logic signed [15:0] out_root_q;
  logic signed [15:0] out_mid_q;
  logic signed [15:0] out_dist_q;
  logic               out_last_q;

  logic               accept;
  logic               load;
  logic               still_in;

  logic [31:0]        lp;
  logic [30:0]        u;
  logic               first_w;
  logic signed [31:0] d_w;
  logic [31+IDX_W:0]  idx_prod;
  logic [IDX_W-1:0]   rom_addr;
  logic [15:0]        rom_data;
  logic signed [15:0] coef;

  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] mul_p;

  logic               prod_neg;
  logic [64:0]        prod_mag;
  logic [64:0]        rnd_sum;
  logic [16:0]        rnd;
  logic signed [17:0] root_s;

  logic [31:0]        lift_sum;
  logic [15:0]        lift_w;
  logic signed [17:0] mid_s;
  logic signed [17:0] dist_s;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign still_in   = !walking_i || (direction_i == tgag_pkg::DIR_STOP);
  assign load       = (state_q == ST_LEG3) && (!out_valid_q || out_ready_i);

  assign lp       = {phase_q[31] ^ tgag_pkg::LAG_MASK[leg_q], phase_q[30:0]};
  assign u        = lp[30:0];
  assign first_w  = !lp[31];
  assign d_w      = first_w ? ({1'b0, u} - 32'sh4000_0000) : (32'sh4000_0000 - {1'b0, u});
  assign idx_prod = (32 + IDX_W)'(u) * (32 + IDX_W)'(DEPTH_C);
  assign rom_addr = idx_prod[30+IDX_W:31];
  assign coef     = dir_q[3] ? 16'sd0 : tgag_pkg::DIR_COEF[dir_q[2:0]][leg_q];

  tgag_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  always_comb begin
    mul_a = 32'sd0;
    mul_b = 33'sd0;
    case (state_q)
      ST_PHASE: begin
        mul_a = {16'b0, dt_q};
        mul_b = {1'b0, rate_q};
      end
      ST_LEG0: begin
        mul_a = {{16{coef[15]}}, coef};
        mul_b = {18'b0, stride_q};
      end
      ST_LEG1: begin
        mul_a = mul_p[31:0];
        mul_b = {d_q[31], d_q};
      end
      ST_LEG2, ST_LEG3: begin
        mul_a = {17'b0, lift_q};
        mul_b = {17'b0, rom_data};
      end
      default: begin
        mul_a = 32'sd0;
        mul_b = 33'sd0;
      end
    endcase
  end

  tgag_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign prod_neg = mul_p[64];
  assign prod_mag = prod_neg ? (-mul_p) : mul_p;
  assign rnd_sum  = prod_mag + (65'd1 << 43);
  assign rnd      = rnd_sum[60:44];
  assign root_s   = prod_neg ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

  assign lift_sum = mul_p[31:0] + 32'd32768;
  assign lift_w   = first_q ? lift_sum[31:16] : 16'd0;
  assign mid_s    = {{2{smid_q[15]}}, smid_q} + $signed({2'b00, lift_w});
  assign dist_s   = {{2{sdist_q[15]}}, sdist_q} - $signed({2'b00, lift_w});

  always_comb begin
    state_d = state_q;
    leg_d   = leg_q;
    phase_d = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          leg_d = 3'd0;
          if (still_in) begin
            phase_d = 32'd0;
            state_d = ST_LEG0;
          end else begin
            state_d = ST_PHASE;
          end
        end
      end
      ST_PHASE: begin
        state_d = ST_ADV;
      end
      ST_ADV: begin
        phase_d = phase_q + mul_p[31:0];
        state_d = ST_LEG0;
      end
      ST_LEG0: begin
        state_d = still_q ? ST_LEG3 : ST_LEG1;
      end
      ST_LEG1: begin
        state_d = ST_LEG2;
      end
      ST_LEG2: begin
        state_d = ST_LEG3;
      end
      ST_LEG3: begin
        if (load) begin
          if (leg_q == tgag_pkg::LEG_LAST) begin
            state_d = ST_IDLE;
          end else begin
            leg_d   = leg_q + 3'd1;
            state_d = ST_LEG0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      leg_q       <= 3'd0;
      phase_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      leg_q   <= leg_d;
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q   <= tgag_pkg::CYCLE_RATE_RST;
      stride_q <= tgag_pkg::STRIDE_RST;
      lift_q   <= tgag_pkg::LIFT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tgag_pkg::REG_CYCLE_RATE: rate_q   <= cfg_data_i;
        tgag_pkg::REG_STRIDE:     stride_q <= cfg_data_i[14:0];
        tgag_pkg::REG_LIFT:       lift_q   <= cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      still_q <= still_in;
      dir_q   <= direction_i;
      dt_q    <= delta_time_i;
      smid_q  <= stand_middle_i;
      sdist_q <= stand_distal_i;
    end
    if (state_q == ST_LEG0) begin
      d_q     <= d_w;
      first_q <= first_w && !still_q;
      root_q  <= 16'sd0;
    end
    if (state_q == ST_LEG2) begin
      root_q <= tgag_pkg::sat18(root_s);
    end
    if (load) begin
      out_leg_q  <= leg_q;
      out_root_q <= root_q;
      out_mid_q  <= tgag_pkg::sat18(mid_s);
      out_dist_q <= tgag_pkg::sat18(dist_s);
      out_last_q <= (leg_q == tgag_pkg::LEG_LAST);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign leg_index_o    = out_leg_q;
  assign root_angle_o   = out_root_q;
  assign middle_angle_o = out_mid_q;
  assign distal_angle_o = out_dist_q;
  assign last_leg_o     = out_last_q;

endmodule

`default_nettype wire

[sim/tripod_gait_angle_checker.sv]
`timescale 1ns / 1ps

module tripod_gait_angle_checker #(
  parameter int unsigned SINE_DEPTH = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tgag_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           walking_i,
  input  logic [3:0]                     direction_i,
  input  logic [15:0]                    delta_time_i,
  input  logic signed [15:0]             stand_middle_i,
  input  logic signed [15:0]             stand_distal_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [2:0]                     leg_index_i,
  input  logic signed [15:0]             root_angle_i,
  input  logic signed [15:0]             middle_angle_i,
  input  logic signed [15:0]             distal_angle_i,
  input  logic                           last_leg_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    poses_due_o
);

  localparam logic [63:0] PI_IN_Q30    = 64'd3373259426;
  localparam logic [5:0]  HALF_BEHIND  = 6'b100110;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam longint      QUARTER_TURN = 64'sd1073741824;

  // Q14 projection of each heading onto the mount tangent of each leg
  localparam int HEADING_COEF [8][6] = '{
    '{ -8192,   8192, -16384,  16384,  -8192,   8192},
    '{  8192,  -8192,  16384, -16384,   8192,  -8192},
    '{ 14189,  14189,      0,      0, -14189, -14189},
    '{-14189, -14189,      0,      0,  14189,  14189},
    '{  4240,  15826, -11585,  11585, -15826,  -4240},
    '{-15826,  -4240, -11585,  11585,   4240,  15826},
    '{ 15826,   4240,  11585, -11585,  -4240, -15826},
    '{ -4240, -15826,  11585, -11585,  15826,   4240}
  };

  typedef struct packed {
    logic [2:0]         leg_index;
    logic signed [15:0] root;
    logic signed [15:0] middle;
    logic signed [15:0] distal;
    logic               last_leg;
  } pose_t;

  pose_t       poses_due [$];
  pose_t       oldest;
  logic [15:0] half_sine [SINE_DEPTH];
  logic [31:0] gait_phase;
  logic [31:0] phase_rate;
  logic [14:0] stride_q12;
  logic [14:0] lift_q12;

  function automatic logic [15:0] half_sine_q16(input int unsigned slot);
    logic [63:0]        k;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    int                 n;
    k = slot;
    if (2 * k > SINE_DEPTH) begin
      k = SINE_DEPTH - k;
    end
    x    = PI_IN_Q30 * k / SINE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    for (n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 8192) / 16384;
    if (acc > 65535) begin
      acc = 65535;
    end
    return acc[15:0];
  endfunction

  function automatic logic signed [15:0] clamp_q12(input longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  task automatic check_field(input string field, input longint expected, input longint actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", field, expected, actual);
      fail_count_o++;
    end
  endtask

  task automatic predict_poses(input logic walking, input logic [3:0] heading,
                               input logic [15:0] dt, input logic signed [15:0] mid_stand,
                               input logic signed [15:0] dist_stand);
    logic        still;
    logic [31:0] leg_phase;
    logic [30:0] u;
    logic        lifting;
    longint      swing;
    longint      coef;
    longint      prod;
    longint      mag;
    longint      lift;
    longint      slot;
    pose_t       p;
    int          leg;
    still = !walking || heading == tgag_pkg::DIR_STOP;
    if (still) begin
      gait_phase = '0;
    end else begin
      gait_phase = gait_phase + dt * phase_rate;
    end
    for (leg = 0; leg < 6; leg++) begin
      p.leg_index = 3'(leg);
      p.last_leg  = (3'(leg) == tgag_pkg::LEG_LAST);
      if (still) begin
        p.root   = '0;
        p.middle = mid_stand;
        p.distal = dist_stand;
      end else begin
        leg_phase = gait_phase + (HALF_BEHIND[leg] ? HALF_TURN : 32'd0);
        u         = leg_phase[30:0];
        lifting   = !leg_phase[31];
        swing     = lifting ? longint'(u) - QUARTER_TURN : QUARTER_TURN - longint'(u);
        coef      = heading[3] ? 0 : longint'(HEADING_COEF[heading[2:0]][leg]);
        prod      = coef * longint'(stride_q12) * swing;
        mag       = (prod < 0) ? -prod : prod;
        mag       = (mag + (longint'(1) <<< 43)) >>> 44;
        p.root    = clamp_q12((prod < 0) ? -mag : mag);
        lift      = 0;
        if (lifting) begin
          slot = (longint'(u) * longint'(SINE_DEPTH)) >>> 31;
          lift = (longint'(lift_q12) * longint'(half_sine[slot]) + 32768) >>> 16;
        end
        p.middle = clamp_q12(longint'(mid_stand) + lift);
        p.distal = clamp_q12(longint'(dist_stand) - lift);
      end
      poses_due.push_back(p);
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < SINE_DEPTH; i++) begin
      half_sine[i] = half_sine_q16(i);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gait_phase   = '0;
      phase_rate   = 32'd4295;
      stride_q12   = 15'd1608;
      lift_q12     = 15'd1229;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tgag_pkg::REG_CYCLE_RATE: phase_rate = cfg_data_i;
          tgag_pkg::REG_STRIDE:     stride_q12 = cfg_data_i[14:0];
          tgag_pkg::REG_LIFT:       lift_q12   = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (poses_due.size() == 0) begin
          $error("unexpected pose transfer for leg %0d", leg_index_i);
          fail_count_o++;
        end else begin
          oldest = poses_due.pop_front();
          check_field("leg_index", longint'(oldest.leg_index), longint'(leg_index_i));
          check_field("root_angle", longint'($signed(oldest.root)), longint'(root_angle_i));
          check_field("middle_angle", longint'($signed(oldest.middle)),
                      longint'(middle_angle_i));
          check_field("distal_angle", longint'($signed(oldest.distal)),
                      longint'(distal_angle_i));
          check_field("last_leg", longint'(oldest.last_leg), longint'(last_leg_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_poses(walking_i, direction_i, delta_time_i, stand_middle_i, stand_distal_i);
      end
    end
    poses_due_o = poses_due.size();
  end

endmodule

[sim/tripod_gait_angle_generator_top_tb.sv]
`timescale 1ns / 1ps

module tripod_gait_angle_generator_top_tb;

  localparam int unsigned                     CLK_PERIOD = 10;
  localparam int unsigned                     SINE_DEPTH = 256;
  localparam int unsigned                     IDLE_LIMIT = 4000;
  localparam int unsigned                     LONG_HOLD  = 400;
  localparam logic [tgag_pkg::CFG_IDX_W-1:0]  REG_UNUSED = 2'd3;

  logic                            clk_i          = 1'b0;
  logic                            rst_ni         = 1'b0;
  logic                            cfg_we_i       = 1'b0;
  logic [tgag_pkg::CFG_IDX_W-1:0]  cfg_index_i    = '0;
  logic [31:0]                     cfg_data_i     = '0;
  logic                            in_valid_i     = 1'b0;
  logic                            in_ready_o;
  logic                            walking_i      = 1'b0;
  logic [3:0]                      direction_i    = '0;
  logic [15:0]                     delta_time_i   = '0;
  logic signed [15:0]              stand_middle_i = '0;
  logic signed [15:0]              stand_distal_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i    = 1'b0;
  logic [2:0]                      leg_index_o;
  logic signed [15:0]              root_angle_o;
  logic signed [15:0]              middle_angle_o;
  logic signed [15:0]              distal_angle_o;
  logic                            last_leg_o;
  int unsigned                     fail_count;
  int unsigned                     poses_due;
  int unsigned                     ticks_sent = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  tripod_gait_angle_generator_top #(
    .SINE_TABLE_DEPTH(SINE_DEPTH)
  ) dut (.*);

  tripod_gait_angle_checker #(
    .SINE_DEPTH(SINE_DEPTH)
  ) pose_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .walking_i      (walking_i),
    .direction_i    (direction_i),
    .delta_time_i   (delta_time_i),
    .stand_middle_i (stand_middle_i),
    .stand_distal_i (stand_distal_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .leg_index_i    (leg_index_o),
    .root_angle_i   (root_angle_o),
    .middle_angle_i (middle_angle_o),
    .distal_angle_i (distal_angle_o),
    .last_leg_i     (last_leg_o),
    .fail_count_o   (fail_count),
    .poses_due_o    (poses_due)
  );

  task automatic send_tick(input logic walking, input logic [3:0] heading,
                           input logic [15:0] dt, input logic signed [15:0] mid_stand,
                           input logic signed [15:0] dist_stand);
    int unsigned gap;
    gap = ((ticks_sent % 48) >= 36) ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    walking_i      <= walking;
    direction_i    <= heading;
    delta_time_i   <= dt;
    stand_middle_i <= mid_stand;
    stand_distal_i <= dist_stand;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    ticks_sent++;
  endtask

  task automatic send_random();
    int unsigned        pick;
    logic [3:0]         heading;
    logic [15:0]        dt;
    logic signed [15:0] mid_stand;
    logic signed [15:0] dist_stand;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      heading = 4'($urandom_range(0, 7));
    end else if (pick < 85) begin
      heading = 4'($urandom_range(9, 15));
    end else if (pick < 92) begin
      heading = tgag_pkg::DIR_STOP;
    end else begin
      heading = 4'($urandom());
    end
    dt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2000)) : 16'($urandom());
    mid_stand = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                            : 16'($urandom_range(0, 16384) - 8192);
    dist_stand = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                             : 16'($urandom_range(0, 16384) - 8192);
    send_tick($urandom_range(0, 9) != 0, heading, dt, mid_stand, dist_stand);
  endtask

  // hold off new ticks until every pose is out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (poses_due != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [tgag_pkg::CFG_IDX_W-1:0] index,
                           input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned gap;
    int unsigned taken;
    int unsigned hold_at;
    taken   = 0;
    hold_at = $urandom_range(200, 270);
    @(posedge rst_ni);
    forever begin
      gap = ((taken % 60) >= 45) ? 0 : $urandom_range(0, 14);
      if (taken == hold_at) begin
        gap = LONG_HOLD;
      end
      if (gap != 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      taken++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int d;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    send_tick(1'b0, 4'd0, 16'd1000, 16'sh7fff, 16'sh8000);
    send_tick(1'b1, tgag_pkg::DIR_STOP, 16'hffff, 16'sh8000, 16'sh7fff);
    send_tick(1'b1, 4'd0, 16'd0, 16'sd0, 16'sd0);
    for (d = 1; d < 16; d++) begin
      if (4'(d) != tgag_pkg::DIR_STOP) begin
        send_tick(1'b1, 4'(d), 16'hffff, (d % 2 != 0) ? 16'sh7fff : 16'sd1024,
                  (d % 2 != 0) ? 16'sh8000 : -16'sd512);
      end
    end
    send_tick(1'b0, 4'hf, 16'hffff, -16'sd300, 16'sd700);
    send_tick(1'b1, 4'd5, 16'd0, 16'sd0, 16'sd0);

    drain();
    write_reg(tgag_pkg::REG_CYCLE_RATE, 32'hffff_ffff);
    write_reg(tgag_pkg::REG_STRIDE, 32'd32767);
    write_reg(tgag_pkg::REG_LIFT, 32'd32767);
    repeat (30) send_random();

    drain();
    write_reg(tgag_pkg::REG_CYCLE_RATE, 32'd0);
    write_reg(tgag_pkg::REG_STRIDE, 32'd0);
    write_reg(tgag_pkg::REG_LIFT, 32'd0);
    repeat (15) send_random();

    drain();
    write_reg(tgag_pkg::REG_CYCLE_RATE, $urandom());
    write_reg(tgag_pkg::REG_STRIDE, $urandom());
    write_reg(REG_UNUSED, $urandom());
    write_reg(tgag_pkg::REG_LIFT, $urandom());
    repeat (20) send_random();
    drain();
    repeat (20) send_random();

    drain();
    write_reg(tgag_pkg::REG_CYCLE_RATE, $urandom_range(1, 300000));
    write_reg(tgag_pkg::REG_STRIDE, $urandom_range(0, 32767));
    write_reg(tgag_pkg::REG_LIFT, $urandom_range(0, 32767));
    repeat (40) send_random();

    drain();
    write_reg(tgag_pkg::REG_CYCLE_RATE, tgag_pkg::CYCLE_RATE_RST);
    write_reg(tgag_pkg::REG_STRIDE, 32'(tgag_pkg::STRIDE_RST));
    write_reg(tgag_pkg::REG_LIFT, 32'(tgag_pkg::LIFT_RST));
    repeat (35) send_random();

    drain();
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && poses_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
